// ===== hw/rtl/dctg_pkg.sv =====
package dctg_pkg;

    localparam int WALL_W    = 48;
    localparam int ACC_W     = 12;
    localparam int ADJ_W     = 32;
    localparam int FRAC_W    = 16;
    localparam int RATE_W    = 24;
    localparam int WHOLE_W   = 4;
    localparam int SECS_W    = 31;
    localparam int DIV_W     = 42;
    localparam int DIV_CNT_W = 6;
    localparam int REM_W     = WALL_W + 1;
    localparam int MCAND_W   = 40;
    localparam int PROD_W    = MCAND_W + ADJ_W;
    localparam int MUL_CNT_W = 5;

    localparam logic [WHOLE_W-1:0] TICK_CAP      = 4'd10;
    localparam logic [ADJ_W-1:0]   ONE_Q30       = 32'h4000_0000;
    localparam logic [ADJ_W-1:0]   RATIO_SAT     = 32'hFFFF_FFFF;
    localparam logic [WALL_W-1:0]  WALL_JUMP_MS  = 48'd1000;
    localparam logic [ACC_W-1:0]   SYNC_WIN_MS   = 12'd1000;
    localparam logic [PROD_W-1:0]  SECS_SAT_LIM  = 72'd1000 << 30;
    // ceil(2^50 / 1000), split at bit 32; exact for products up to 1000 ms in Q30
    localparam logic [31:0]        RECIP1K_LO    = 32'h24DD_2F1B;
    localparam logic [8:0]         RECIP1K_HI    = 9'h106;
    localparam logic [ADJ_W-1:0]   RECIP5        = 32'hCCCC_CCCD;
    localparam logic [RATE_W-1:0]  TPS_RESET     = 24'd5120;
    localparam logic [RATE_W-1:0]  SPEED_RESET   = 24'd65536;

    localparam logic OP_START  = 1'b0;

    // register map, byte address / 4
    localparam logic REG_TPS   = 1'b0;
    localparam logic REG_SPEED = 1'b1;

    typedef struct packed {
        logic accept;
        logic wall_step;
        logic div_ratio;
        logic ratio_take;
        logic ease;
        logic dm_step;
        logic mul_step;
        logic mul_check;
        logic secs_take;
        logic tick1;
        logic tick2;
        logic tick3;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic need_sync;
        logic sync_div;
        logic dm_mul;
        logic mul_last;
        logic mul_sat;
        logic div_busy;
        logic out_busy;
    } dp_sts_t;

endpackage

// ===== hw/rtl/dctg_divider.sv =====
module dctg_divider (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [dctg_pkg::DIV_W-1:0]       dividend,
    input  logic [dctg_pkg::WALL_W-1:0]      divisor,
    output logic                             busy,
    output logic [dctg_pkg::DIV_W-1:0]       quotient
);

    logic                               busy_reg, busy_next;
    logic [dctg_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [dctg_pkg::REM_W-1:0]         rem_reg, rem_next;
    logic [dctg_pkg::DIV_W-1:0]         quo_reg, quo_next;
    logic [dctg_pkg::WALL_W-1:0]        dvs_reg, dvs_next;
    logic [dctg_pkg::REM_W-1:0]         trial;
    logic                               fits;

    // restoring, one quotient bit per cycle, MSB first
    assign trial = {rem_reg[dctg_pkg::WALL_W-1:0], quo_reg[dctg_pkg::DIV_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? trial - {1'b0, dvs_reg} : trial;
            quo_next = {quo_reg[dctg_pkg::DIV_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == dctg_pkg::DIV_CNT_W'(dctg_pkg::DIV_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/dctg_datapath.sv =====
module dctg_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  dctg_pkg::dp_cmd_t               cmd,
    output dctg_pkg::dp_sts_t               sts,
    input  logic                            in_op,
    input  logic [dctg_pkg::WALL_W-1:0]     in_wall,
    input  logic [dctg_pkg::WALL_W-1:0]     in_mono,
    input  logic [dctg_pkg::RATE_W-1:0]     tps,
    input  logic [dctg_pkg::RATE_W-1:0]     speed,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata
);

    localparam int W = dctg_pkg::WALL_W;

    logic [W-1:0]                     wall_reg, mono_reg;
    logic [W-1:0]                     last_wall_reg, sync_mono_reg, last_mono_reg;
    logic [dctg_pkg::ACC_W-1:0]       accum_reg;
    logic [dctg_pkg::ADJ_W-1:0]       adj_reg, ratio_reg;
    logic [dctg_pkg::FRAC_W-1:0]      frac_reg;
    logic [dctg_pkg::SECS_W-1:0]      secs_reg;
    logic [dctg_pkg::MCAND_W-1:0]     mcand_reg;
    logic [dctg_pkg::ADJ_W-1:0]       mpl_reg;
    logic [dctg_pkg::PROD_W-1:0]      prod_reg;
    logic [dctg_pkg::MUL_CNT_W-1:0]   mcnt_reg;
    logic [63:0]                      recip_lo_reg;
    logic [32:0]                      scaled_reg;
    logic [40:0]                      inc_reg;
    logic [dctg_pkg::WHOLE_W-1:0]     res_whole_reg;
    logic [dctg_pkg::FRAC_W-1:0]      res_part_reg;
    logic                             out_valid_reg;
    logic [23:0]                      out_data_reg;

    logic [W-1:0]                     wd, md, dm;
    logic                             jump, md_pos, dm_pos, adj_zero;
    logic [dctg_pkg::ACC_W-1:0]       sum;
    logic                             div_start, div_busy;
    logic [dctg_pkg::DIV_W-1:0]       div_dividend, quo;
    logic [W-1:0]                     div_divisor;
    logic [32:0]                      delta;
    logic [dctg_pkg::ADJ_W-1:0]       mag;
    logic [63:0]                      mag_x;
    logic [29:0]                      fifth;
    logic [40:0]                      rc_a;
    logic [39:0]                      rc_b;
    logic [16:0]                      rc_c;
    logic [49:0]                      recip_acc;
    logic [54:0]                      sp_prod;
    logic [56:0]                      rt_prod;
    logic [41:0]                      total;

    assign wd       = wall_reg - last_wall_reg;
    assign jump     = wd[W-1] | (wd > dctg_pkg::WALL_JUMP_MS);
    assign sum      = accum_reg + wd[dctg_pkg::ACC_W-1:0];
    assign md       = mono_reg - sync_mono_reg;
    assign md_pos   = !md[W-1] && (md != '0);
    assign dm       = mono_reg - last_mono_reg;
    assign dm_pos   = !dm[W-1] && (dm != '0);
    assign adj_zero = (adj_reg == '0);

    assign sts.need_sync = !jump && (sum > dctg_pkg::SYNC_WIN_MS);
    assign sts.sync_div  = sts.need_sync && md_pos;
    assign sts.dm_mul    = dm_pos && !adj_zero && (dm[W-1:dctg_pkg::MCAND_W] == '0);
    assign sts.mul_last  = (mcnt_reg == '1);
    assign sts.mul_sat   = (prod_reg >= dctg_pkg::SECS_SAT_LIM);
    assign sts.div_busy  = div_busy;
    assign sts.out_busy  = out_valid_reg;

    // divider: drift ratio only
    assign div_start    = cmd.div_ratio;
    assign div_dividend = {sum, 30'b0};
    assign div_divisor  = md;

    dctg_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (quo)
    );

    // ease by a fifth, truncating toward zero
    assign delta = {1'b0, ratio_reg} - {1'b0, adj_reg};
    assign mag   = delta[32] ? dctg_pkg::ADJ_W'(-delta) : delta[31:0];
    assign mag_x = mag * dctg_pkg::RECIP5;
    assign fifth = mag_x[63:34];

    // ms to seconds: (prod * ceil(2^50/1000)) >> 50, low partial product registered
    assign rc_a      = prod_reg[31:0] * dctg_pkg::RECIP1K_HI;
    assign rc_b      = prod_reg[39:32] * dctg_pkg::RECIP1K_LO;
    assign rc_c      = prod_reg[39:32] * dctg_pkg::RECIP1K_HI;
    assign recip_acc = {18'b0, recip_lo_reg[63:32]} + {9'b0, rc_a} + {10'b0, rc_b}
                     + {1'b0, rc_c, 32'b0};

    assign sp_prod = secs_reg * speed;
    assign rt_prod = scaled_reg * tps;
    assign total   = {26'b0, frac_reg} + {1'b0, inc_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_wall_reg <= '0;
            sync_mono_reg <= '0;
            last_mono_reg <= '0;
            accum_reg     <= '0;
            adj_reg       <= dctg_pkg::ONE_Q30;
            frac_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.accept && in_op == dctg_pkg::OP_START) begin
                last_wall_reg <= in_wall;
                sync_mono_reg <= in_mono;
                frac_reg      <= '0;
                adj_reg       <= dctg_pkg::ONE_Q30;
            end
            if (cmd.wall_step) begin
                last_wall_reg <= wall_reg;
                if (jump) begin
                    last_mono_reg <= mono_reg;
                end else begin
                    accum_reg <= sum;
                end
            end
            if (cmd.ease) begin
                adj_reg       <= delta[32] ? adj_reg - 32'(fifth) : adj_reg + 32'(fifth);
                sync_mono_reg <= mono_reg;
                accum_reg     <= '0;
            end
            if (cmd.dm_step) begin
                last_mono_reg <= mono_reg;
            end
            if (cmd.tick3) begin
                frac_reg <= total[15:0];
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            wall_reg      <= in_wall;
            mono_reg      <= in_mono;
            res_whole_reg <= '0;
            res_part_reg  <= '0;
        end
        if (cmd.wall_step) begin
            ratio_reg <= dctg_pkg::RATIO_SAT;
        end
        if (cmd.ratio_take) begin
            ratio_reg <= (quo[dctg_pkg::DIV_W-1:32] != '0) ? dctg_pkg::RATIO_SAT : quo[31:0];
        end
        if (cmd.dm_step) begin
            if (!dm_pos || adj_zero) begin
                secs_reg <= '0;
            end else begin
                secs_reg <= dctg_pkg::SECS_W'(dctg_pkg::ONE_Q30);
            end
            mcand_reg <= dm[dctg_pkg::MCAND_W-1:0];
            mpl_reg   <= adj_reg;
            prod_reg  <= '0;
            mcnt_reg  <= '0;
        end
        if (cmd.mul_step) begin
            prod_reg <= {prod_reg[dctg_pkg::PROD_W-2:0], 1'b0}
                      + (mpl_reg[dctg_pkg::ADJ_W-1] ?
                         {32'b0, mcand_reg} : dctg_pkg::PROD_W'(0));
            mpl_reg  <= {mpl_reg[dctg_pkg::ADJ_W-2:0], 1'b0};
            mcnt_reg <= mcnt_reg + 1'b1;
        end
        if (cmd.mul_check) begin
            if (sts.mul_sat) begin
                secs_reg <= dctg_pkg::SECS_W'(dctg_pkg::ONE_Q30);
            end else begin
                recip_lo_reg <= prod_reg[31:0] * dctg_pkg::RECIP1K_LO;
            end
        end
        if (cmd.secs_take) begin
            secs_reg <= recip_acc[48:18];
        end
        if (cmd.tick1) begin
            scaled_reg <= sp_prod[54:22];
        end
        if (cmd.tick2) begin
            inc_reg <= rt_prod[56:16];
        end
        if (cmd.tick3) begin
            res_part_reg  <= total[15:0];
            res_whole_reg <= (total[41:16] > 26'(dctg_pkg::TICK_CAP)) ?
                             dctg_pkg::TICK_CAP : total[19:16];
        end
        if (cmd.out_load) begin
            out_data_reg <= {4'b0, res_part_reg, res_whole_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== hw/rtl/dctg_ctrl.sv =====
module dctg_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                in_op,
    input  dctg_pkg::dp_sts_t   sts,
    output dctg_pkg::dp_cmd_t   cmd
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_WALL  = 12'b0000_0000_0010,
        S_DIVR  = 12'b0000_0000_0100,
        S_EASE  = 12'b0000_0000_1000,
        S_DM    = 12'b0000_0001_0000,
        S_MUL   = 12'b0000_0010_0000,
        S_MCHK  = 12'b0000_0100_0000,
        S_DIVS  = 12'b0000_1000_0000,
        S_TICK1 = 12'b0001_0000_0000,
        S_TICK2 = 12'b0010_0000_0000,
        S_TICK3 = 12'b0100_0000_0000,
        S_OUT   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = (in_op == dctg_pkg::OP_START) ? S_OUT : S_WALL;
                end
            end
            S_WALL: begin
                cmd.wall_step = 1'b1;
                if (sts.sync_div) begin
                    cmd.div_ratio = 1'b1;
                    state_next    = S_DIVR;
                end else if (sts.need_sync) begin
                    state_next = S_EASE;
                end else begin
                    state_next = S_DM;
                end
            end
            S_DIVR: begin
                if (!sts.div_busy) begin
                    cmd.ratio_take = 1'b1;
                    state_next     = S_EASE;
                end
            end
            S_EASE: begin
                cmd.ease   = 1'b1;
                state_next = S_DM;
            end
            S_DM: begin
                cmd.dm_step = 1'b1;
                state_next  = sts.dm_mul ? S_MUL : S_TICK1;
            end
            S_MUL: begin
                cmd.mul_step = 1'b1;
                if (sts.mul_last) begin
                    state_next = S_MCHK;
                end
            end
            S_MCHK: begin
                cmd.mul_check = 1'b1;
                state_next    = sts.mul_sat ? S_TICK1 : S_DIVS;
            end
            S_DIVS: begin
                cmd.secs_take = 1'b1;
                state_next    = S_TICK1;
            end
            S_TICK1: begin
                cmd.tick1  = 1'b1;
                state_next = S_TICK2;
            end
            S_TICK2: begin
                cmd.tick2  = 1'b1;
                state_next = S_TICK3;
            end
            S_TICK3: begin
                cmd.tick3  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/drift_corrected_tick_generator_top.sv =====
// Path, accept to m_tvalid: a start beat goes straight to the output register; an update
//   beat runs the wall check and tick scaling, with the shift-add multiply and reciprocal
//   scale when needed, the easing step when drift is eased, and the ratio divide on sync.
// Throughput: one beat in flight; s_tready returns the cycle after the result is loaded,
//   and the load itself waits while the previous result waits on m_tready.
// Reset: aresetn synchronous, active low; clears state, sets adjust to 1.0 and the
//   registers to 20.0 ticks/s and speed 1.0.
module drift_corrected_tick_generator_top (
    input  logic         aclk,
    input  logic         aresetn,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // [47:0] wall_ms, [95:48] mono_ms
    input  logic [0:0]   s_tuser,   // [0] op (0 start, 1 update)
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,   // [3:0] whole_ticks, [19:4] partial_tick, rest zero
    // config port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [dctg_pkg::RATE_W-1:0] tps_reg, speed_reg;
    logic                        cfg_wr;
    logic                        cfg_sel;
    dctg_pkg::dp_cmd_t           cmd;
    dctg_pkg::dp_sts_t           sts;

    // config: register i at byte 4*i, written on the access phase
    assign pready  = 1'b1;
    assign cfg_sel = paddr[2];
    assign cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tps_reg   <= dctg_pkg::TPS_RESET;
            speed_reg <= dctg_pkg::SPEED_RESET;
        end else if (cfg_wr) begin
            if (cfg_sel == dctg_pkg::REG_TPS) begin
                tps_reg <= pwdata[dctg_pkg::RATE_W-1:0];
            end else begin
                speed_reg <= pwdata[dctg_pkg::RATE_W-1:0];
            end
        end
    end

    assign prdata = (cfg_sel == dctg_pkg::REG_TPS) ? {8'b0, tps_reg} : {8'b0, speed_reg};

    // sequencer: walks wall check, drift easing, seconds, tick scaling
    dctg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_op    (s_tuser[0]),
        .sts      (sts),
        .cmd      (cmd)
    );

    // clock state, ratio divider, serial multiplier, output register
    dctg_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .in_op    (s_tuser[0]),
        .in_wall  (s_tdata[47:0]),
        .in_mono  (s_tdata[95:48]),
        .tps      (tps_reg),
        .speed    (speed_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
